[rtl/core/sps_pkg.sv]
`timescale 1ns / 1ps
// sps_pkg: request types, segment kind codes and the CORDIC arctangent table.
// No dependencies; used by sps_cordic, stroke_point_smoother and tb.
package sps_pkg;

	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_LINE  = 2'd1;
	localparam logic [1:0] KIND_QUAD  = 2'd2;

	localparam int ATAN_ENTRIES = 24;
	localparam logic [12:0] FULL_TURN16 = 13'd5760;

	// atan(2^-i) in units of 2^-20 degree
	localparam logic [25:0] ATAN_DEG20 [ATAN_ENTRIES] = '{
		26'd47185920, 26'd27855475, 26'd14718068, 26'd7471121, 26'd3750058,
		26'd1876857, 26'd938658, 26'd469357, 26'd234682, 26'd117342,
		26'd58671, 26'd29335, 26'd14668, 26'd7334, 26'd3667, 26'd1833,
		26'd917, 26'd458, 26'd229, 26'd115, 26'd57, 26'd29, 26'd14, 26'd7
	};

	typedef struct packed {
		logic signed [15:0] point_x;
		logic signed [15:0] point_y;
		logic               stroke_start;
	} point_t;

	typedef struct packed {
		logic [1:0]         segment_kind;
		logic signed [15:0] from_x;
		logic signed [15:0] from_y;
		logic signed [15:0] ctrl_x;
		logic signed [15:0] ctrl_y;
		logic signed [15:0] to_x;
		logic signed [15:0] to_y;
	} segment_t;

endpackage

[rtl/core/sps_sqrt.sv]
`timescale 1ns / 1ps
// sps_sqrt: bit-pair iterative square root with round to nearest.
// Depends on nothing but the clock and reset.
module sps_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [34:0] radicand,
	output logic        done,
	output logic [16:0] root
);
	logic [34:0] rem_q;
	logic [34:0] r_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [34:0] bit_w;
	logic [34:0] trial;

	assign bit_w = 35'd1 << {cnt_q, 1'b0};
	assign trial = r_q + bit_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= 5'd16;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			r_q   <= '0;
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				r_q   <= (r_q >> 1) + bit_w;
			end else begin
				r_q <= r_q >> 1;
			end
		end
	end

	assign done = done_q;
	assign root = (rem_q > r_q) ? 17'(r_q + 35'd1) : r_q[16:0];
endmodule

[rtl/core/sps_cordic.sv]
`timescale 1ns / 1ps
// sps_cordic: iterative CORDIC vectoring, one rotation per cycle, angle out
// in 1/16 degree. Depends on sps_pkg for the arctangent table.
module sps_cordic #(
	parameter int STEPS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [16:0] dx,
	input  logic signed [16:0] dy,
	output logic               done,
	output logic [12:0]        angle
);
	import sps_pkg::*;

	localparam int IW = $clog2(STEPS);

	logic signed [27:0] vx_q, vy_q;
	logic signed [31:0] z_q;
	logic [IW-1:0]      i_q;
	logic               busy_q, done_q, zero_q;
	logic signed [27:0] vx0, vy0, sx, sy;
	logic signed [31:0] atan_w, zp, zc;
	logic [13:0]        a_raw;

	assign vx0 = 28'(dx) <<< 8;
	assign vy0 = -(28'(dy) <<< 8);
	assign sx  = vx_q >>> i_q;
	assign sy  = vy_q >>> i_q;
	assign atan_w = 32'(ATAN_DEG20[5'(i_q)]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			i_q    <= '0;
		end else if (busy_q) begin
			if (i_q == IW'(STEPS - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				i_q <= i_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (dx == 17'sd0) && (dy == 17'sd0);
			if (vx0 < 0) begin
				vx_q <= -vx0;
				vy_q <= -vy0;
				z_q  <= 32'sd188743680;
			end else begin
				vx_q <= vx0;
				vy_q <= vy0;
				z_q  <= '0;
			end
		end else if (busy_q) begin
			if (vy_q > 0) begin
				vx_q <= vx_q + sy;
				vy_q <= vy_q - sx;
				z_q  <= z_q + atan_w;
			end else begin
				vx_q <= vx_q - sy;
				vy_q <= vy_q + sx;
				z_q  <= z_q - atan_w;
			end
		end
	end

	always_comb begin
		zp = (z_q < 0) ? z_q + 32'sd377487360 : z_q;
		zc = (zp < 0) ? 32'sd0 : zp;
		a_raw = 14'((zc + 32'sd32768) >>> 16);
		if (zero_q)
			angle = '0;
		else if (a_raw >= 14'(FULL_TURN16))
			angle = 13'(a_raw - 14'(FULL_TURN16));
		else
			angle = a_raw[12:0];
	end

	assign done = done_q;
endmodule

[rtl/core/stroke_point_smoother.sv]
`timescale 1ns / 1ps
// stroke_point_smoother: top level, sequencer, state and output register.
// Depends on sps_pkg, sps_sqrt and sps_cordic.
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------
//  in       | in_valid / in_stall  | in_data  (point_t)
//  out      | out_valid / out_stall| out_data (segment_t)
//  cfg      | cfg_valid / cfg_ready| cfg_data (min_dist)
//
// A stroke start point goes from IDLE straight to FIN; any other point passes SQ1,
// SQ2, RUN and FIN, RUN waiting for the 17-step root and the CORDIC run side by side.
// One request at a time: in_stall is high from acceptance until done.
// A held result under out_stall blocks only the finish of the next request.
// Reset clears the state to no point seen and min_dist to 16.
module stroke_point_smoother #(
	parameter int ANGLE_THRESHOLD_SIXTEENTHS = 480,
	parameter int CORDIC_STEPS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  sps_pkg::point_t   in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output sps_pkg::segment_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [15:0]       cfg_data
);
	import sps_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_SQ1  = 3'd1;
	localparam logic [2:0] ST_SQ2  = 3'd2;
	localparam logic [2:0] ST_RUN  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]         state_q;
	logic [15:0]        min_dist_q;
	logic [1:0]         point_index_q;
	logic signed [15:0] last_x_q, last_y_q, pen_x_q, pen_y_q, x_q, y_q;
	logic [12:0]        last_angle_q;
	logic [15:0]        run_length_q;
	logic signed [16:0] dx_q, dy_q;
	logic [33:0]        sq_q;
	logic               first_q;
	logic               out_valid_q;
	segment_t           out_q;

	logic               accept, sq_go, sqrt_done, cordic_done;
	logic [34:0]        radicand;
	logic [16:0]        len;
	logic [12:0]        ang;
	logic signed [16:0] sq_op;
	logic signed [33:0] prod;
	logic [17:0]        run_sum;
	logic [15:0]        run_sat;
	logic signed [13:0] adiff;
	logic [13:0]        amag;
	logic signed [16:0] mx_w, my_w;
	logic               emit, out_free, fin_go;
	segment_t           seg;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	// one squarer, dx in SQ1 and dy in SQ2
	assign sq_op    = (state_q == ST_SQ1) ? dx_q : dy_q;
	assign prod     = sq_op * sq_op;
	assign radicand = 35'(sq_q) + 35'(unsigned'(prod));
	assign sq_go    = (state_q == ST_SQ2);

	sps_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_go), .radicand(radicand),
		.done(sqrt_done), .root(len)
	);

	sps_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(sq_go), .dx(dx_q), .dy(dy_q),
		.done(cordic_done), .angle(ang)
	);

	always_comb begin
		run_sum = 18'(run_length_q) + 18'(len);
		run_sat = (run_sum > 18'd65535) ? 16'hFFFF : run_sum[15:0];
		adiff   = 14'(ang) - 14'(last_angle_q);
		amag    = (adiff < 0) ? 14'(-adiff) : 14'(adiff);
		mx_w    = (17'(last_x_q) + 17'(x_q)) >>> 1;
		my_w    = (17'(last_y_q) + 17'(y_q)) >>> 1;
		seg     = '0;
		emit    = 1'b0;
		if (first_q) begin
			emit = 1'b1;
			seg.segment_kind = KIND_START;
			seg.from_x = x_q;
			seg.from_y = y_q;
			seg.to_x   = x_q;
			seg.to_y   = y_q;
		end else begin
			seg.from_x = pen_x_q;
			seg.from_y = pen_y_q;
			seg.to_x   = mx_w[15:0];
			seg.to_y   = my_w[15:0];
			if (point_index_q == 2'd1) begin
				emit = (run_sat >= min_dist_q);
				seg.segment_kind = KIND_LINE;
			end else begin
				emit = (run_sat >= min_dist_q) ||
					(amag > 14'(ANGLE_THRESHOLD_SIXTEENTHS));
				seg.segment_kind = KIND_QUAD;
				seg.ctrl_x = last_x_q;
				seg.ctrl_y = last_y_q;
			end
		end
	end

	assign out_free = !out_valid_q || !out_stall;
	assign fin_go   = (state_q == ST_FIN) && (!emit || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			min_dist_q    <= 16'd16;
			point_index_q <= 2'd0;
			last_x_q      <= '0;
			last_y_q      <= '0;
			pen_x_q       <= '0;
			pen_y_q       <= '0;
			last_angle_q  <= '0;
			run_length_q  <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				min_dist_q <= cfg_data;
			if (fin_go && emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= (in_data.stroke_start || point_index_q == 2'd0) ?
							ST_FIN : ST_SQ1;
				end
				ST_SQ1: state_q <= ST_SQ2;
				ST_SQ2: state_q <= ST_RUN;
				ST_RUN: begin
					if (sqrt_done && cordic_done)
						state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						last_x_q <= x_q;
						last_y_q <= y_q;
						if (first_q) begin
							point_index_q <= 2'd1;
							pen_x_q       <= x_q;
							pen_y_q       <= y_q;
							last_angle_q  <= '0;
							run_length_q  <= '0;
						end else begin
							point_index_q <= 2'd2;
							last_angle_q  <= ang;
							run_length_q  <= emit ? 16'd0 : run_sat;
							if (emit) begin
								pen_x_q <= mx_w[15:0];
								pen_y_q <= my_w[15:0];
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q     <= in_data.point_x;
			y_q     <= in_data.point_y;
			first_q <= in_data.stroke_start || (point_index_q == 2'd0);
			dx_q    <= 17'(in_data.point_x) - 17'(last_x_q);
			dy_q    <= 17'(in_data.point_y) - 17'(last_y_q);
		end
		if (state_q == ST_SQ1)
			sq_q <= unsigned'(prod);
		if (fin_go && emit)
			out_q <= seg;
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken while busy");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.segment_kind == KIND_START ||
			out_data.segment_kind == KIND_LINE || out_data.segment_kind == KIND_QUAD))
		else $error("illegal segment kind");

	a_line_no_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.segment_kind != KIND_QUAD) |->
			(out_data.ctrl_x == 16'sd0 && out_data.ctrl_y == 16'sd0))
		else $error("control point set on non-quadratic segment");

	a_fin_only_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && !(sqrt_done && cordic_done)) |=> (state_q == ST_RUN))
		else $error("left run before units finished");
endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// tb: self-checking bench for stroke_point_smoother; directed and random pen strokes.
// Checks each segment against an in-bench midpoint smoother model (root + CORDIC).
// Depends on sps_pkg and stroke_point_smoother.
module tb;
	import sps_pkg::*;

	localparam int ANGLE_LIMIT = 480;
	localparam int CORDIC_RUNS = 16;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     in_valid = 1'b0;
	logic     in_stall;
	point_t   in_data = '0;
	logic     out_valid;
	logic     out_stall = 1'b0;
	segment_t out_data;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic [15:0] cfg_data = '0;

	point_t   pending_points[$];
	segment_t expected_segments[$];
	int       n_accepted = 0;
	int       n_mismatch = 0;
	int       hold_cnt = 0;
	bit       hold_done = 1'b0;
	bit       calm;

	// smoother state
	int unsigned min_dist_m = 16;
	int          pt_index = 0;
	int          last_x = 0, last_y = 0, pen_x = 0, pen_y = 0, last_ang = 0;
	int unsigned run_len = 0;

	stroke_point_smoother #(
		.ANGLE_THRESHOLD_SIXTEENTHS(ANGLE_LIMIT),
		.CORDIC_STEPS(CORDIC_RUNS)
	) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	assign calm = (n_accepted >= 250 && n_accepted < 420);

	function automatic int unsigned step_length(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		if (n > r)
			r++;
		return int'(r);
	endfunction

	function automatic int step_angle(longint dx, longint dy);
		longint vx, vy, z, nx, ny, a;
		vx = dx * 256;
		vy = -dy * 256;
		z = 0;
		if (dx == 0 && dy == 0)
			return 0;
		if (vx < 0) begin
			vx = -vx;
			vy = -vy;
			z = 64'sd180 * 1048576;
		end
		for (int i = 0; i < CORDIC_RUNS && i < ATAN_ENTRIES; i++) begin
			if (vy > 0) begin
				nx = vx + (vy >>> i);
				ny = vy - (vx >>> i);
				z = z + longint'(ATAN_DEG20[i]);
			end else begin
				nx = vx - (vy >>> i);
				ny = vy + (vx >>> i);
				z = z - longint'(ATAN_DEG20[i]);
			end
			vx = nx;
			vy = ny;
		end
		if (z < 0)
			z = z + 64'sd360 * 1048576;
		if (z < 0)
			z = 0;
		a = (z + 32768) >>> 16;
		while (a >= 5760)
			a = a - 5760;
		return int'(a);
	endfunction

	function automatic void smooth_point(point_t p);
		int x, y, ang, mx, my;
		longint dx, dy, diff;
		bit emit;
		segment_t s;
		x = int'(p.point_x);
		y = int'(p.point_y);
		emit = 1'b0;
		s = '0;
		if (p.stroke_start || pt_index == 0) begin
			pt_index = 1;
			last_x = x; pen_x = x;
			last_y = y; pen_y = y;
			last_ang = 0;
			run_len = 0;
			s.segment_kind = KIND_START;
			s.from_x = 16'(x); s.from_y = 16'(y); s.to_x = 16'(x); s.to_y = 16'(y);
			expected_segments.push_back(s);
			return;
		end
		dx = longint'(x) - last_x;
		dy = longint'(y) - last_y;
		ang = step_angle(dx, dy);
		run_len = run_len + step_length(longint'(dx * dx) + longint'(dy * dy));
		if (run_len > 65535)
			run_len = 65535;
		mx = int'((longint'(last_x) + x) >>> 1);
		my = int'((longint'(last_y) + y) >>> 1);
		s.from_x = 16'(pen_x); s.from_y = 16'(pen_y); s.to_x = 16'(mx); s.to_y = 16'(my);
		if (pt_index == 1) begin
			if (run_len >= min_dist_m) begin
				s.segment_kind = KIND_LINE;
				emit = 1'b1;
			end
			pt_index = 2;
		end else begin
			diff = longint'(ang) - last_ang;
			if (diff < 0)
				diff = -diff;
			if (run_len >= min_dist_m || diff > ANGLE_LIMIT) begin
				s.segment_kind = KIND_QUAD;
				s.ctrl_x = 16'(last_x); s.ctrl_y = 16'(last_y);
				emit = 1'b1;
			end
		end
		if (emit) begin
			expected_segments.push_back(s);
			pen_x = mx;
			pen_y = my;
			run_len = 0;
		end
		last_x = x;
		last_y = y;
		last_ang = ang;
	endfunction

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				smooth_point(in_data);
				void'(pending_points.pop_front());
				n_accepted <= n_accepted + 1;
			end
			if (!(in_valid && in_stall)) begin
				if (pending_points.size() > 0 && (calm || $urandom_range(99) >= 31)) begin
					in_valid <= 1'b1;
					in_data <= pending_points[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall, with one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (!hold_done && n_accepted >= 600) begin
				hold_done <= 1'b1;
				hold_cnt <= 300;
				out_stall <= 1'b1;
			end else begin
				if (hold_cnt > 0)
					hold_cnt <= hold_cnt - 1;
				out_stall <= (hold_cnt > 1) || (!calm && $urandom_range(99) < 31);
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		segment_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_segments.size() == 0) begin
				n_mismatch <= n_mismatch + 1;
				if (n_mismatch < 10)
					$display("unexpected segment %p", out_data);
			end else begin
				e = expected_segments.pop_front();
				if (out_data.segment_kind !== e.segment_kind || out_data.from_x !== e.from_x
					|| out_data.from_y !== e.from_y || out_data.ctrl_x !== e.ctrl_x
					|| out_data.ctrl_y !== e.ctrl_y || out_data.to_x !== e.to_x
					|| out_data.to_y !== e.to_y) begin
					n_mismatch <= n_mismatch + 1;
					if (n_mismatch < 10)
						$display("segment mismatch: exp %p got %p", e, out_data);
				end
			end
		end
	end

	task automatic write_min_dist(logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do
			@(posedge clk);
		while (!cfg_ready);
		min_dist_m = 32'(v);
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		do
			@(posedge clk);
		while (pending_points.size() > 0 || in_valid || expected_segments.size() > 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic add_point(int x, int y, bit s);
		point_t p;
		p.point_x = x[15:0];
		p.point_y = y[15:0];
		p.stroke_start = s;
		pending_points.push_back(p);
	endtask

	task automatic add_strokes(int n);
		int x, y, dx, dy, len, span;
		while (n > 0) begin
			if ($urandom_range(9) == 0) begin
				add_point($urandom(), $urandom(), 1'($urandom_range(1)));
				n--;
			end else begin
				x = $urandom();
				y = $urandom();
				len = $urandom_range(1, 12);
				case ($urandom_range(3))
					0: span = 8;
					1, 2: span = 64;
					default: span = 2000;
				endcase
				dx = $urandom_range(2 * span) - span;
				dy = $urandom_range(2 * span) - span;
				add_point(x, y, 1'b1);
				n--;
				for (int i = 1; i < len && n > 0; i++) begin
					if ($urandom_range(3) == 0) begin
						dx = $urandom_range(2 * span) - span;
						dy = $urandom_range(2 * span) - span;
					end else begin
						dx = dx + $urandom_range(4) - 2;
						dy = dy + $urandom_range(4) - 2;
					end
					x = x + dx;
					y = y + dy;
					add_point(x, y, 1'b0);
					n--;
				end
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		write_min_dist(16'd16);
		add_point(100, 100, 1'b0);
		add_point(100, 100, 1'b0);
		add_point(200, 100, 1'b0);
		add_point(-32768, -32768, 1'b1);
		add_point(32767, 32767, 1'b0);
		add_point(32767, -32768, 1'b0);
		add_point(-32768, 32767, 1'b0);
		add_point(0, 0, 1'b1);
		add_point(160, 0, 1'b0);
		add_point(160, 160, 1'b0);
		add_point(161, 160, 1'b0);
		add_point(162, 160, 1'b0);
		add_point(162, 161, 1'b0);
		add_strokes(270);
		wait_idle();
		write_min_dist(16'd0);
		add_point(5, 5, 1'b1);
		add_point(5, 5, 1'b0);
		add_point(5, 5, 1'b0);
		add_strokes(400);
		wait_idle();
		write_min_dist(16'hFFFF);
		add_point(0, 0, 1'b1);
		add_point(100, 0, 1'b0);
		add_point(200, 3, 1'b0);
		add_point(200, 300, 1'b0);
		add_strokes(200);
		wait_idle();
		write_min_dist(16'($urandom_range(20, 400)));
		add_strokes(240);
		wait_idle();
		write_min_dist(16'd1);
		add_strokes(220);
		wait_idle();
		if (n_mismatch == 0 && expected_segments.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("FAIL");
		$finish;
	end

endmodule
